// ===== rtl/plpc_pkg.sv =====
// Shared constants, types and helpers for the nearest palette color search block.
`timescale 1ns / 1ps

package plpc_pkg;

    localparam int PALETTE_SIZE_DEF = 256;
    localparam int CH_W             = 8;
    localparam int RGB_W            = 3 * CH_W;
    localparam int FACTOR_W         = 9;
    localparam int DIST_W           = 18;
    localparam int OP_W             = 2;

    localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
    localparam logic [OP_W-1:0] OP_MATCH  = 2'd1;
    localparam logic [OP_W-1:0] OP_DARKEN = 2'd2;

    // Issue side of the scan pipeline
    typedef struct packed {
        logic start;   // reload the running best before a new scan
        logic issue;   // one palette entry read issued this cycle
    } plpc_scan_t;

    // (c * f) >> 8, clamped to full scale
    function automatic logic [CH_W-1:0] darken_chan(logic [CH_W-1:0] c,
                                                    logic [FACTOR_W-1:0] f);
        logic [CH_W+FACTOR_W-1:0] prod;
        logic [FACTOR_W-1:0]      scaled;
        prod   = (CH_W + FACTOR_W)'(c) * (CH_W + FACTOR_W)'(f);
        scaled = prod[CH_W+FACTOR_W-1:CH_W];
        return (scaled > FACTOR_W'(8'hFF)) ? 8'hFF : scaled[CH_W-1:0];
    endfunction

endpackage

// ===== rtl/plpc_if.sv =====
// Valid/ready channel interfaces for command and result words.
`timescale 1ns / 1ps

interface plpc_cmd_if;
    import plpc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [OP_W-1:0]       operation;
    logic [7:0]            entry_index;
    logic [CH_W-1:0]       red;
    logic [CH_W-1:0]       green;
    logic [CH_W-1:0]       blue;
    logic [FACTOR_W-1:0]   factor;

    modport source (output valid, operation, entry_index, red, green, blue, factor,
                    input ready);
    modport sink   (input valid, operation, entry_index, red, green, blue, factor,
                    output ready);
endinterface

interface plpc_res_if;
    import plpc_pkg::*;
    logic              valid;
    logic              ready;
    logic [7:0]        matched_index;
    logic [DIST_W-1:0] best_distance;

    modport source (output valid, matched_index, best_distance, input ready);
    modport sink   (input valid, matched_index, best_distance, output ready);
endinterface

// ===== rtl/plpc_mem.sv =====
// Palette storage: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module plpc_mem
    import plpc_pkg::*;
#(
    parameter int DEPTH = PALETTE_SIZE_DEF,
    parameter int AW    = $clog2(PALETTE_SIZE_DEF)
)(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [RGB_W-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [RGB_W-1:0] rdata
);

    logic [RGB_W-1:0] mem [DEPTH];
    logic [RGB_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/plpc_dist.sv =====
// Scan pipeline: channel differences, squares, then sum and running minimum.
`timescale 1ns / 1ps

module plpc_dist
    import plpc_pkg::*;
#(
    parameter int AW = $clog2(PALETTE_SIZE_DEF)
)(
    input  logic              clk,
    input  logic              rst_n,
    input  plpc_scan_t        ctl,
    input  logic [AW-1:0]     idx,
    input  logic [CH_W-1:0]   tgt_r,
    input  logic [CH_W-1:0]   tgt_g,
    input  logic [CH_W-1:0]   tgt_b,
    input  logic [RGB_W-1:0]  rdata,
    output logic              busy,
    output logic [AW-1:0]     best_idx,
    output logic [DIST_W-1:0] best_dist
);

    // p1: read data in flight, p2: abs differences, p3: squares
    logic                  p1_v_reg, p2_v_reg, p3_v_reg;
    logic [AW-1:0]         p1_idx_reg, p2_idx_reg, p3_idx_reg;
    logic [CH_W-1:0]       ad_r_reg, ad_g_reg, ad_b_reg;
    logic [2*CH_W-1:0]     sq_r_reg, sq_g_reg, sq_b_reg;
    logic [AW-1:0]         best_idx_reg, best_idx_next;
    logic [DIST_W-1:0]     best_dist_reg, best_dist_next;

    logic [CH_W-1:0]       ch_r, ch_g, ch_b;
    logic [DIST_W-1:0]     sum;

    function automatic logic [CH_W-1:0] absdiff(logic [CH_W-1:0] a, logic [CH_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    assign ch_r = rdata[3*CH_W-1:2*CH_W];
    assign ch_g = rdata[2*CH_W-1:CH_W];
    assign ch_b = rdata[CH_W-1:0];

    assign sum = DIST_W'(sq_r_reg) + DIST_W'(sq_g_reg) + DIST_W'(sq_b_reg);

    always_comb
    begin
        best_idx_next  = best_idx_reg;
        best_dist_next = best_dist_reg;
        if (ctl.start)
        begin
            best_idx_next  = '0;
            best_dist_next = '1;   // above any reachable distance
        end
        else if (p3_v_reg && (sum < best_dist_reg))
        begin
            // strict compare keeps the lowest index on ties
            best_idx_next  = p3_idx_reg;
            best_dist_next = sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_v_reg      <= 1'b0;
            p2_v_reg      <= 1'b0;
            p3_v_reg      <= 1'b0;
            best_idx_reg  <= '0;
            best_dist_reg <= '1;
        end
        else
        begin
            p1_v_reg      <= ctl.issue;
            p2_v_reg      <= p1_v_reg;
            p3_v_reg      <= p2_v_reg;
            best_idx_reg  <= best_idx_next;
            best_dist_reg <= best_dist_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_idx_reg <= idx;
        p2_idx_reg <= p1_idx_reg;
        p3_idx_reg <= p2_idx_reg;
        ad_r_reg   <= absdiff(ch_r, tgt_r);
        ad_g_reg   <= absdiff(ch_g, tgt_g);
        ad_b_reg   <= absdiff(ch_b, tgt_b);
        sq_r_reg   <= (2*CH_W)'(ad_r_reg) * (2*CH_W)'(ad_r_reg);
        sq_g_reg   <= (2*CH_W)'(ad_g_reg) * (2*CH_W)'(ad_g_reg);
        sq_b_reg   <= (2*CH_W)'(ad_b_reg) * (2*CH_W)'(ad_b_reg);
    end

    assign busy      = p1_v_reg | p2_v_reg | p3_v_reg;
    assign best_idx  = best_idx_reg;
    assign best_dist = best_dist_reg;

endmodule

// ===== rtl/nearest_palette_color_search_top.sv =====
// Top level of the nearest palette color search block.
`timescale 1ns / 1ps

// Nearest palette color search. The palette (PALETTE_SIZE entries of 24-bit RGB)
// lives in one single-port-write, registered-read memory. After reset a clearing
// pass writes zero to every entry, one per cycle, so cmd.ready stays low until
// the pass ends. Each command word yields exactly one result word. A palette
// write goes from accept straight to the finish state. A color match scans the
// memory one entry per cycle through a 3-stage difference/square/compare
// pipeline; a darkened match reads the stored entry first and darkens it into
// the target. The memory read port, one address per cycle, sets the
// scan length. One command is in work at a time; a new command is taken while
// the previous result still sits in the output register. Ties go to the lowest
// index; for palettes above 256 entries matched_index holds the low 8 bits.
module nearest_palette_color_search_top
    import plpc_pkg::*;
#(
    parameter int PALETTE_SIZE = PALETTE_SIZE_DEF
)(
    input  logic       clk,
    input  logic       rst_n,
    plpc_cmd_if.sink   cmd,
    plpc_res_if.source res
);

    localparam int AW = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(PALETTE_SIZE - 1);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_DARK  = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_DRAIN = 3'd4;
    localparam logic [2:0] ST_FIN   = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [AW-1:0]       cnt_reg, cnt_next;
    logic [OP_W-1:0]     op_reg, op_next;
    logic [CH_W-1:0]     tgt_r_reg, tgt_r_next;
    logic [CH_W-1:0]     tgt_g_reg, tgt_g_next;
    logic [CH_W-1:0]     tgt_b_reg, tgt_b_next;
    logic [FACTOR_W-1:0] factor_reg, factor_next;
    logic                oob_reg, oob_next;
    logic [7:0]          res_idx_reg, res_idx_next;
    logic [DIST_W-1:0]   res_dist_reg, res_dist_next;
    logic                out_valid_reg, out_valid_next;
    logic [7:0]          out_idx_reg, out_idx_next;
    logic [DIST_W-1:0]   out_dist_reg, out_dist_next;

    logic                accept;
    logic                in_range;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [RGB_W-1:0]    mem_wdata;
    logic [AW-1:0]       mem_raddr;
    logic [RGB_W-1:0]    mem_rdata;
    logic [RGB_W-1:0]    dark_src;
    plpc_scan_t          scan_ctl;
    logic                scan_busy;
    logic [AW-1:0]       best_idx;
    logic [DIST_W-1:0]   best_dist;
    logic                out_load;

    assign cmd.ready = (state_reg == ST_IDLE);
    assign accept    = cmd.valid && cmd.ready;
    assign in_range  = ({24'd0, cmd.entry_index} < 32'(PALETTE_SIZE));

    // Write port: clearing pass after reset, otherwise palette writes
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = cnt_reg;
        mem_wdata = '0;
        if (state_reg == ST_CLEAR)
        begin
            mem_we = 1'b1;
        end
        else if (accept && (cmd.operation == OP_WRITE) && in_range)
        begin
            mem_we    = 1'b1;
            mem_waddr = AW'(cmd.entry_index);
            mem_wdata = {cmd.red, cmd.green, cmd.blue};
        end
    end

    // While idle, read the addressed entry so a darken command finds it next cycle
    assign mem_raddr = (state_reg == ST_IDLE) ? AW'(cmd.entry_index) : cnt_reg;

    assign scan_ctl.issue = (state_reg == ST_SCAN);
    assign scan_ctl.start = (state_reg == ST_SCAN) && (cnt_reg == '0);

    assign dark_src = oob_reg ? '0 : mem_rdata;
    assign out_load = (state_reg == ST_FIN) && (!out_valid_reg || res.ready);

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        op_next       = op_reg;
        tgt_r_next    = tgt_r_reg;
        tgt_g_next    = tgt_g_reg;
        tgt_b_next    = tgt_b_reg;
        factor_next   = factor_reg;
        oob_next      = oob_reg;
        res_idx_next  = res_idx_reg;
        res_dist_next = res_dist_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_ADDR)
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next     = cmd.operation;
                    tgt_r_next  = cmd.red;
                    tgt_g_next  = cmd.green;
                    tgt_b_next  = cmd.blue;
                    factor_next = cmd.factor;
                    oob_next    = !in_range;
                    cnt_next    = '0;
                    unique case (cmd.operation)
                        OP_WRITE:
                        begin
                            res_idx_next  = cmd.entry_index;
                            res_dist_next = '0;
                            state_next    = ST_FIN;
                        end
                        OP_MATCH:  state_next = ST_SCAN;
                        OP_DARKEN: state_next = ST_DARK;
                        default:
                        begin
                            // reserved op: no effect, zero result
                            res_idx_next  = '0;
                            res_dist_next = '0;
                            state_next    = ST_FIN;
                        end
                    endcase
                end
            end
            ST_DARK:
            begin
                tgt_r_next = darken_chan(dark_src[3*CH_W-1:2*CH_W], factor_reg);
                tgt_g_next = darken_chan(dark_src[2*CH_W-1:CH_W], factor_reg);
                tgt_b_next = darken_chan(dark_src[CH_W-1:0], factor_reg);
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_ADDR)
                begin
                    cnt_next   = '0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!scan_busy)
                begin
                    res_idx_next  = 8'(best_idx);
                    res_dist_next = best_dist;
                    state_next    = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_idx_next   = out_idx_reg;
        out_dist_next  = out_dist_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_idx_next   = res_idx_reg;
            out_dist_next  = res_dist_reg;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        tgt_r_reg    <= tgt_r_next;
        tgt_g_reg    <= tgt_g_next;
        tgt_b_reg    <= tgt_b_next;
        factor_reg   <= factor_next;
        oob_reg      <= oob_next;
        res_idx_reg  <= res_idx_next;
        res_dist_reg <= res_dist_next;
        out_idx_reg  <= out_idx_next;
        out_dist_reg <= out_dist_next;
    end

    assign res.valid         = out_valid_reg;
    assign res.matched_index = out_idx_reg;
    assign res.best_distance = out_dist_reg;

    plpc_mem #(
        .DEPTH (PALETTE_SIZE),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    plpc_dist #(
        .AW (AW)
    ) u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (scan_ctl),
        .idx       (cnt_reg),
        .tgt_r     (tgt_r_reg),
        .tgt_g     (tgt_g_reg),
        .tgt_b     (tgt_b_reg),
        .rdata     (mem_rdata),
        .busy      (scan_busy),
        .best_idx  (best_idx),
        .best_dist (best_dist)
    );

    // Palette is only written by the clearing pass or in idle, never mid-scan
    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN || state_reg == ST_DRAIN || state_reg == ST_DARK) |-> !mem_we)
        else $error("palette written during a search");

    // Result word appears only out of the finish state
    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res.valid) |-> $past(state_reg) == ST_FIN)
        else $error("result raised outside finish state");

    // A write command reports distance zero
    a_write_dist_zero: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res.valid) && ($past(op_reg) == OP_WRITE) |-> res.best_distance == '0)
        else $error("write result with nonzero distance");

    // The pipeline is drained before the result is taken
    a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN) |-> !scan_busy)
        else $error("scan pipeline busy at finish");

endmodule
